// ===== design/idrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte step for the identity record validator.
// No dependencies; imported by every module of the block.
`default_nettype none

package idrc_pkg;

    localparam int POS_W    = 5;
    localparam int UNIT_LEN = 11;
    localparam int UNIT_IDX_W = 4;
    localparam int CFG_IDX_W  = 2;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [1:0]            status_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // record layout
    localparam pos_t POS_MAGIC0     = 5'd0;
    localparam pos_t POS_MAGIC1     = 5'd1;
    localparam pos_t POS_CAGE_LO    = 5'd2;
    localparam pos_t POS_CAGE_HI    = 5'd3;
    localparam pos_t POS_UNIT_FIRST = 5'd4;
    localparam pos_t POS_UNIT_END   = 5'd15;
    localparam pos_t POS_TIME_FIRST = 5'd16;
    localparam pos_t POS_CRC_SPAN   = 5'd20;
    localparam pos_t POS_CRC_LO     = 5'd20;
    localparam pos_t POS_LAST       = 5'd21;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    localparam status_t STATUS_VALID = 2'd0;
    localparam status_t STATUS_MAGIC = 2'd1;
    localparam status_t STATUS_CRC   = 2'd2;

    localparam cfg_idx_t CFG_MAGIC_FIRST  = 2'd0;
    localparam cfg_idx_t CFG_MAGIC_SECOND = 2'd1;

    localparam logic [7:0] MAGIC_FIRST_RST  = 8'd73;
    localparam logic [7:0] MAGIC_SECOND_RST = 8'd68;

    typedef struct packed {
        status_t     status;
        logic [15:0] cage_number;
        logic [63:0] unit_chars_low;
        logic [23:0] unit_chars_high;
        logic [31:0] time_stamp;
        logic [15:0] crc_stored;
        logic [15:0] crc_computed;
    } idrc_result_t;

    // one byte of CRC-16, MSB first, unreflected
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/idrc_track.sv =====
// Record tracker: byte position, running CRC, magic check and field capture.
// Builds the result word on the last record byte. Depends on idrc_pkg.
`default_nettype none

module idrc_track (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  record_start,
    input  wire logic [7:0]            magic_first,
    input  wire logic [7:0]            magic_second,
    output logic                       is_last,
    output idrc_pkg::idrc_result_t     res
);
    import idrc_pkg::*;

    pos_t        pos_reg, pos_next, pos_eff;
    logic [15:0] crc_reg, crc_next, crc_base;
    logic        magic_ok_reg, magic_ok_next, magic_base;
    logic [15:0] cage_reg;
    logic [7:0]  unit_reg [UNIT_LEN];
    logic [31:0] time_reg;
    logic [7:0]  crc_low_reg;
    logic [UNIT_IDX_W-1:0] unit_idx;
    logic        unit_we;
    logic [15:0] stored;
    status_t     st;
    logic        ok;

    always_comb
    begin
        // record_start and out-of-range positions restart the record
        pos_eff    = (record_start || pos_reg > POS_LAST) ? POS_MAGIC0 : pos_reg;
        crc_base   = (pos_eff == POS_MAGIC0) ? CRC_INIT : crc_reg;
        magic_base = (pos_eff == POS_MAGIC0) ? 1'b1 : magic_ok_reg;
        crc_next   = (pos_eff < POS_CRC_SPAN) ? crc_step(crc_base, data_byte) : crc_base;

        magic_ok_next = magic_base;
        if (pos_eff == POS_MAGIC0 && data_byte != magic_first)
        begin
            magic_ok_next = 1'b0;
        end
        if (pos_eff == POS_MAGIC1 && data_byte != magic_second)
        begin
            magic_ok_next = 1'b0;
        end

        is_last  = (pos_eff == POS_LAST);
        pos_next = is_last ? POS_MAGIC0 : pos_eff + 5'd1;

        unit_we  = (pos_eff >= POS_UNIT_FIRST) && (pos_eff < POS_UNIT_END);
        unit_idx = UNIT_IDX_W'(pos_eff - POS_UNIT_FIRST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_MAGIC0;
            crc_reg      <= CRC_INIT;
            magic_ok_reg <= 1'b1;
            cage_reg     <= 16'h0000;
            time_reg     <= 32'h0000_0000;
            crc_low_reg  <= 8'h00;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            magic_ok_reg <= magic_ok_next;
            if (pos_eff == POS_CAGE_LO)
            begin
                cage_reg[7:0] <= data_byte;
            end
            if (pos_eff == POS_CAGE_HI)
            begin
                cage_reg[15:8] <= data_byte;
            end
            if (pos_eff >= POS_TIME_FIRST && pos_eff < POS_CRC_SPAN)
            begin
                unique case (pos_eff[1:0])
                    2'd0:    time_reg[7:0]   <= data_byte;
                    2'd1:    time_reg[15:8]  <= data_byte;
                    2'd2:    time_reg[23:16] <= data_byte;
                    default: time_reg[31:24] <= data_byte;
                endcase
            end
            if (pos_eff == POS_CRC_LO)
            begin
                crc_low_reg <= data_byte;
            end
        end
    end

    // unit characters: no reset, each entry written before it is read
    always_ff @(posedge clk)
    begin
        if (accept && unit_we)
        begin
            unit_reg[unit_idx] <= data_byte;
        end
    end

    always_comb
    begin
        stored = {data_byte, crc_low_reg};
        if (!magic_ok_reg)
        begin
            st = STATUS_MAGIC;
        end
        else if (stored != crc_base)
        begin
            st = STATUS_CRC;
        end
        else
        begin
            st = STATUS_VALID;
        end
        ok = (st == STATUS_VALID);

        res.status          = st;
        res.cage_number     = ok ? cage_reg : 16'h0000;
        res.unit_chars_low  = ok ? {unit_reg[7], unit_reg[6], unit_reg[5], unit_reg[4],
                                    unit_reg[3], unit_reg[2], unit_reg[1], unit_reg[0]}
                                 : 64'h0;
        res.unit_chars_high = ok ? {unit_reg[10], unit_reg[9], unit_reg[8]} : 24'h0;
        res.time_stamp      = ok ? time_reg : 32'h0;
        res.crc_stored      = stored;
        res.crc_computed    = crc_base;
    end

endmodule

`default_nettype wire

// ===== design/idrc_outreg.sv =====
// Result output register with valid/stall handshake.
// Holds one result word until the consumer takes it. Depends on idrc_pkg.
`default_nettype none

module idrc_outreg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire idrc_pkg::idrc_result_t res_d,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic                       hold,
    output idrc_pkg::idrc_result_t     res_q
);
    import idrc_pkg::*;

    logic         valid_reg;
    idrc_result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_d;
        end
    end

    assign out_valid = valid_reg;
    assign hold      = valid_reg && out_stall;
    assign res_q     = data_reg;

endmodule

`default_nettype wire

// ===== design/id_record_crc16_validator.sv =====
// Top level of the identity record CRC-16 validator: config registers and handshakes.
// Uses idrc_track and idrc_outreg; depends on idrc_pkg.
//
//  channel   signals                              direction  word
//  input     in_valid / in_stall                  in         data_byte, record_start
//  output    out_valid / out_stall                out        status .. crc_computed
//  config    cfg_valid / cfg_ready                in         cfg_index, cfg_data
//
// One byte per cycle, except while the last record byte stalls; the record state updates on the accepting edge.
// A result appears on out_valid in the cycle after the last record byte (byte 21) is accepted.
// Bytes other than the last are taken even while a result waits; the last byte
// stalls only while the output register is full and stalled.
// Reset restores magic bytes to 'I','D' and restarts at record byte 0.
`default_nettype none

module id_record_crc16_validator (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   record_start,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [1:0]                  status,
    output logic [15:0]                 cage_number,
    output logic [63:0]                 unit_chars_low,
    output logic [23:0]                 unit_chars_high,
    output logic [31:0]                 time_stamp,
    output logic [15:0]                 crc_stored,
    output logic [15:0]                 crc_computed,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire idrc_pkg::cfg_idx_t     cfg_index,
    input  wire logic [7:0]             cfg_data
);
    import idrc_pkg::*;

    logic [7:0]   magic_first_reg, magic_second_reg;
    logic         accept, is_last, hold;
    idrc_result_t res_d, res_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_first_reg  <= MAGIC_FIRST_RST;
            magic_second_reg <= MAGIC_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAGIC_FIRST:  magic_first_reg  <= cfg_data;
                CFG_MAGIC_SECOND: magic_second_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_stall = hold && is_last;
    assign accept   = in_valid && !in_stall;

    idrc_track u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .record_start (record_start),
        .magic_first  (magic_first_reg),
        .magic_second (magic_second_reg),
        .is_last      (is_last),
        .res          (res_d)
    );

    idrc_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && is_last),
        .res_d     (res_d),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .hold      (hold),
        .res_q     (res_q)
    );

    assign status          = res_q.status;
    assign cage_number     = res_q.cage_number;
    assign unit_chars_low  = res_q.unit_chars_low;
    assign unit_chars_high = res_q.unit_chars_high;
    assign time_stamp      = res_q.time_stamp;
    assign crc_stored      = res_q.crc_stored;
    assign crc_computed    = res_q.crc_computed;

endmodule

`default_nettype wire

// ===== bench/id_record_crc16_validator_test.sv =====
`timescale 1ns / 1ps
// Testbench for id_record_crc16_validator: streams 22-byte identity records, predicts each
// verdict in a scoreboard class and compares it field by field. Depends on idrc_pkg.

module id_record_crc16_validator_test;
    import idrc_pkg::*;

    typedef logic [7:0] rec_t [22];
    typedef enum {REC_GOOD, REC_BAD_MAGIC, REC_BAD_CRC, REC_BAD_BOTH} rec_kind_e;

    // Tracks the record state of the block and queues the verdict each record should produce.
    class record_checker;
        logic [7:0]   magic0;
        logic [7:0]   magic1;
        pos_t         pos;
        logic [15:0]  crc;
        bit           magic_ok;
        logic [15:0]  cage;
        logic [7:0]   units [UNIT_LEN];
        logic [31:0]  stamp;
        logic [7:0]   crc_lo;
        idrc_result_t verdicts [$];
        int           errors;
        int           bytes_taken;
        int           n_valid;
        int           n_magic;
        int           n_crc;

        function new();
            magic0 = MAGIC_FIRST_RST;
            magic1 = MAGIC_SECOND_RST;
            pos = '0;
            crc = CRC_INIT;
            magic_ok = 1'b1;
            cage = '0;
            foreach (units[k]) units[k] = '0;
            stamp = '0;
            crc_lo = '0;
        endfunction

        static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++)
                r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
            return r;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [7:0] v);
            case (idx)
                CFG_MAGIC_FIRST:  magic0 = v;
                CFG_MAGIC_SECOND: magic1 = v;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, bit first);
            idrc_result_t v;
            logic [15:0]  stored;
            int           p;
            bit           ok;
            bytes_taken++;
            if (first)
                pos = '0;
            p = pos;
            if (p > POS_LAST)
                p = 0;
            if (p == POS_MAGIC0)
            begin
                crc = CRC_INIT;
                magic_ok = 1'b1;
            end
            if (p < POS_CRC_SPAN)
                crc = crc_byte(crc, b);
            if (p == POS_MAGIC0)
            begin
                if (b != magic0)
                    magic_ok = 1'b0;
            end
            else if (p == POS_MAGIC1)
            begin
                if (b != magic1)
                    magic_ok = 1'b0;
            end
            else if (p == POS_CAGE_LO)
                cage[7:0] = b;
            else if (p == POS_CAGE_HI)
                cage[15:8] = b;
            else if (p >= POS_UNIT_FIRST && p < POS_UNIT_END)
                units[p - POS_UNIT_FIRST] = b;
            else if (p >= POS_TIME_FIRST && p < POS_CRC_SPAN)
                stamp[8 * (p - POS_TIME_FIRST) +: 8] = b;
            else if (p == POS_CRC_LO)
                crc_lo = b;

            if (p < POS_LAST)
            begin
                pos = pos_t'(p + 1);
                return;
            end

            stored = {b, crc_lo};
            if (!magic_ok)
                v.status = STATUS_MAGIC;
            else if (stored != crc)
                v.status = STATUS_CRC;
            else
                v.status = STATUS_VALID;
            ok = (v.status == STATUS_VALID);
            v.cage_number = ok ? cage : '0;
            v.unit_chars_low = '0;
            v.unit_chars_high = '0;
            if (ok)
            begin
                for (int k = 0; k < 8; k++)
                    v.unit_chars_low[8 * k +: 8] = units[k];
                for (int k = 0; k < 3; k++)
                    v.unit_chars_high[8 * k +: 8] = units[8 + k];
            end
            v.time_stamp = ok ? stamp : '0;
            v.crc_stored = stored;
            v.crc_computed = crc;
            verdicts.push_back(v);
            pos = '0;
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_result(idrc_result_t got);
            idrc_result_t want;
            if (verdicts.size() == 0)
            begin
                $error("result word with no record pending: status %0d", got.status);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            case (want.status)
                STATUS_VALID: n_valid++;
                STATUS_MAGIC: n_magic++;
                default:      n_crc++;
            endcase
            cmp("status", want.status, got.status);
            cmp("cage_number", want.cage_number, got.cage_number);
            cmp("unit_chars_low", want.unit_chars_low, got.unit_chars_low);
            cmp("unit_chars_high", want.unit_chars_high, got.unit_chars_high);
            cmp("time_stamp", want.time_stamp, got.time_stamp);
            cmp("crc_stored", want.crc_stored, got.crc_stored);
            cmp("crc_computed", want.crc_computed, got.crc_computed);
        endfunction

        function void drain_check();
            if (verdicts.size() != 0)
            begin
                $error("%0d expected verdicts never arrived", verdicts.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        record_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] cage_number;
    logic [63:0] unit_chars_low;
    logic [23:0] unit_chars_high;
    logic [31:0] time_stamp;
    logic [15:0] crc_stored;
    logic [15:0] crc_computed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_MAGIC_FIRST;
    logic [7:0]  cfg_data = 8'h00;

    bit steady = 1'b0;
    record_checker chk = new();

    id_record_crc16_validator u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input bit first);
        while (!steady && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        record_start <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chk.take_byte(b, first);
    endtask

    task automatic send_span(input rec_t rec, input int from, input int upto, input bit first);
        for (int k = from; k < upto; k++)
            send_byte(rec[k], (k == from) && first);
    endtask

    // leaves cfg_valid high so back-to-back writes need no toggle; caller lowers it
    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        chk.set_reg(idx, v);
    endtask

    task automatic load_magic(input logic [7:0] m0, input logic [7:0] m1);
        write_reg(CFG_MAGIC_FIRST, m0);
        write_reg(CFG_MAGIC_SECOND, m1);
        cfg_valid <= 1'b0;
    endtask

    // drain pending verdicts, then allow for the output register latency
    task automatic settle();
        in_valid <= 1'b0;
        while (chk.verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void make_record(input rec_kind_e kind, input int fill,
                                        input logic [7:0] m0, input logic [7:0] m1,
                                        output rec_t rec);
        logic [15:0] c;
        int          which;
        for (int k = 0; k < 22; k++)
            rec[k] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
        rec[0] = m0;
        rec[1] = m1;
        if (kind == REC_BAD_MAGIC || kind == REC_BAD_BOTH)
        begin
            which = $urandom_range(0, 2);
            if (which != 1)
                rec[0] ^= 8'($urandom_range(1, 255));
            if (which != 0)
                rec[1] ^= 8'($urandom_range(1, 255));
        end
        c = CRC_INIT;
        for (int k = 0; k < 20; k++)
            c = record_checker::crc_byte(c, rec[k]);
        rec[20] = c[7:0];
        rec[21] = c[15:8];
        if (kind == REC_BAD_CRC || kind == REC_BAD_BOTH)
            rec[20 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
    endfunction

    task automatic run_phase(input int nrec);
        rec_t      rec;
        rec_kind_e kind;
        bit        need_start;
        int        r;
        int        cut;
        int        fill;
        need_start = 1'b1;
        repeat (nrec)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                if (r < 55)
                    kind = REC_GOOD;
                else if (r < 62)
                    kind = REC_BAD_MAGIC;
                else if (r < 69)
                    kind = REC_BAD_CRC;
                else if (r < 75)
                    kind = REC_BAD_BOTH;
                else
                    kind = rec_kind_e'($urandom_range(0, 3));
                fill = -1;
                if ($urandom_range(0, 19) == 0)
                    fill = $urandom_range(0, 1) ? 255 : 0;
                make_record(kind, fill, chk.magic0, chk.magic1, rec);
                // truncated records get dropped by the next record_start
                cut = (r >= 75) ? $urandom_range(1, 21) : 22;
                send_span(rec, 0, cut, need_start || $urandom_range(0, 1));
                need_start = (cut < 22);
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                need_start = 1'b1;
            end
        end
        settle();
    endtask

    // result side: random stalls plus occasional long stalls to back up the last byte
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                chk.match_result({status, cage_number, unit_chars_low, unit_chars_high,
                                  time_stamp, crc_stored, crc_computed});
            if (steady)
                out_stall <= 1'b0;
            else if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 299) == 0)
            begin
                burst = $urandom_range(20, 40);
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    initial
    begin
        rec_t rec;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset magic, all-zero and all-one payloads, rollover without record_start
        make_record(REC_GOOD, 0, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b1);
        make_record(REC_GOOD, 255, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b0);
        make_record(REC_BAD_MAGIC, -1, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b0);
        make_record(REC_BAD_CRC, -1, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b1);
        make_record(REC_BAD_BOTH, -1, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b1);
        // partial record abandoned by a new start
        make_record(REC_GOOD, -1, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 9, 1'b1);
        make_record(REC_GOOD, -1, chk.magic0, chk.magic1, rec);
        send_span(rec, 0, 22, 1'b1);
        settle();

        // magic registers change after byte 0: byte 0 keeps the old compare value
        make_record(REC_GOOD, -1, chk.magic0, 8'h5A, rec);
        send_span(rec, 0, 1, 1'b1);
        settle();
        write_reg(CFG_MAGIC_FIRST, 8'h00);
        write_reg(CFG_MAGIC_SECOND, 8'h5A);
        cfg_valid <= 1'b0;
        send_span(rec, 1, 22, 1'b0);
        settle();

        load_magic(8'h00, 8'hFF);
        run_phase(14);
        load_magic(8'hFF, 8'h00);
        steady = 1'b1;
        run_phase(14);
        steady = 1'b0;
        load_magic(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_phase(14);
        load_magic(MAGIC_FIRST_RST, MAGIC_SECOND_RST);
        run_phase(14);

        repeat (10) @(posedge clk);
        chk.drain_check();
        $display("Streamed %0d record bytes under six magic settings;", chk.bytes_taken);
        $display("verdicts seen: %0d valid, %0d magic mismatch, %0d crc mismatch",
                 chk.n_valid, chk.n_magic, chk.n_crc);
        if (chk.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d verdicts pending", chk.verdicts.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
